>>> hw/rtl/wdtf_pkg.sv
// ============================================================================
// wdtf_pkg - shared types and constants for the task-file disk controller
// Holds the transfer structs, the command and state codes, and the status bits.
// ============================================================================
package wdtf_pkg;

    localparam int BUFFER_WORDS_DEF = 256;
    localparam int NUM_DRIVES_DEF   = 2;

    // item commands
    localparam logic [2:0] OP_HOST_RD = 3'd0;
    localparam logic [2:0] OP_HOST_WR = 3'd1;
    localparam logic [2:0] OP_HOST_BW = 3'd2;
    localparam logic [2:0] OP_FILL    = 3'd3;
    localparam logic [2:0] OP_DRAIN   = 3'd4;
    localparam logic [2:0] OP_DONE    = 3'd5;

    // task-file commands
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_GEOM  = 8'h91;

    // status bits
    localparam logic [7:0] ST_BUSY  = 8'h80;
    localparam logic [7:0] ST_READY = 8'h40;
    localparam logic [7:0] ST_DRQ   = 8'h08;
    localparam logic [7:0] ST_ERR   = 8'h01;

    // register offsets
    localparam logic [4:0] RO_DATA = 5'd0;
    localparam logic [4:0] RO_ERR  = 5'd2;
    localparam logic [4:0] RO_SCNT = 5'd4;
    localparam logic [4:0] RO_SECT = 5'd6;
    localparam logic [4:0] RO_CYLL = 5'd8;
    localparam logic [4:0] RO_CYLH = 5'd10;
    localparam logic [4:0] RO_DRHD = 5'd12;
    localparam logic [4:0] RO_CMD  = 5'd14;
    localparam logic [4:0] RO_CTRL = 5'd16;
    localparam logic [4:0] RO_NUL  = 5'd18;

    typedef enum logic [1:0] {OPS_IDLE, OPS_READ, OPS_WRITE} ops_t;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL1, S_MUL2, S_OUT
    } ctl_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  reg_offset;
        logic [15:0] write_data;
        logic        io_error;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        bad_access;
        logic        start_transfer;
        logic        transfer_dir;
        logic        transfer_drive;
        logic [27:0] block_address;
        logic        seek_fault;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;    // apply item, sample start request
        logic mul1;    // first product stage
        logic mul2;    // second product stage
        logic load_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start;   // the item starts a sector transfer
    } dp_sts_t;

endpackage

>>> hw/rtl/wdtf_ram.sv
// ============================================================================
// wdtf_ram - generic single-port RAM
// One write and one registered read per cycle.
// ============================================================================
module wdtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/wdtf_ctrl.sv
// ============================================================================
// wdtf_ctrl - sequencer for the task-file controller
// Takes one item, steps the datapath through execute, two multiply stages when
// the item starts a transfer, and result load, then holds the result until it is taken.
// ============================================================================
module wdtf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  wdtf_pkg::dp_sts_t sts,
    output wdtf_pkg::dp_cmd_t cmd
);
    import wdtf_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = sts.start ? S_MUL1 : S_OUT;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_OUT;
            S_OUT:   if (!ovalid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_EXEC:  cmd.exec = 1'b1;
            S_MUL1:  cmd.mul1 = 1'b1;
            S_MUL2:  cmd.mul2 = 1'b1;
            S_OUT:   cmd.load_out = !ovalid_reg || !out_stall;
            default: cmd = '0;
        endcase
    end

    // output register valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        if (cmd.load_out)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
endmodule

>>> hw/rtl/wdtf_dp.sv
// ============================================================================
// wdtf_dp - task-file registers, sector buffer and block address datapath
// Holds the register window, geometry, pointers and the result register.
// ============================================================================
module wdtf_dp #(
    parameter int BUFFER_WORDS = wdtf_pkg::BUFFER_WORDS_DEF,
    parameter int NUM_DRIVES   = wdtf_pkg::NUM_DRIVES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_take,
    input  wdtf_pkg::in_item_t           in_item,
    input  logic [NUM_DRIVES-1:0]        drive_present,
    input  wdtf_pkg::dp_cmd_t            cmd,
    output wdtf_pkg::dp_sts_t            sts,
    output wdtf_pkg::out_item_t          out_item
);
    import wdtf_pkg::*;

    localparam int PW = $clog2(BUFFER_WORDS);
    localparam int DW = $clog2(NUM_DRIVES);

    in_item_t          it_reg;
    logic [PW-1:0]     hptr_reg, dptr_reg;
    logic [7:0]        scnt_reg, sect_reg, cyll_reg, cylh_reg, drhd_reg, cmd_reg;
    logic [7:0]        stat_reg, prec_reg, ctrl_reg;
    ops_t              ops_reg;
    logic [DW-1:0]     sel_reg;
    logic              sfl_reg;
    logic [7:0]        gsec_reg [NUM_DRIVES];
    logic [4:0]        ghd_reg  [NUM_DRIVES];
    logic [15:0]       gcyl_reg [NUM_DRIVES];
    out_item_t         res_reg;
    logic              start_reg, dir_reg, fault_reg;
    logic [15:0]       rdv_reg;
    logic              rdsel_reg, berr_reg;
    logic [20:0]       p1_reg;
    logic [27:0]       ba_reg;
    logic [3:0]        head_reg;
    logic [7:0]        secm1_reg, gs_reg;
    logic [15:0]       cyl_s_reg;
    logic [4:0]        gh_reg;
    logic              exec_d_reg;
    logic [15:0]       ramq_reg;

    // sector buffer
    logic              ram_we;
    logic [PW-1:0]     ram_addr;
    logic [15:0]       ram_wdata, ram_rdata;

    wdtf_ram #(.WIDTH(16), .DEPTH(BUFFER_WORDS)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // decode of the latched item
    logic        host_wr, is_rd, is_fill, is_drain, is_done;
    logic [7:0]  b;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [DW-1:0] d;

    always_comb
    begin
        host_wr  = it_reg.command == OP_HOST_WR ||
                   (it_reg.command == OP_HOST_BW && !it_reg.reg_offset[0]);
        is_rd    = it_reg.command == OP_HOST_RD;
        is_fill  = it_reg.command == OP_FILL;
        is_drain = it_reg.command == OP_DRAIN;
        is_done  = it_reg.command == OP_DONE;
        b        = it_reg.write_data[7:0];
        cyl      = {cylh_reg, cyll_reg};
        head     = drhd_reg[3:0];
        d        = sel_reg;
    end

    // buffer port: address from the latched item, used in the exec cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = hptr_reg;
        ram_wdata = {8'h00, b};
        if (is_fill || is_drain)
            ram_addr = dptr_reg;
        if (cmd.exec)
        begin
            if (is_fill)
            begin
                ram_we    = 1'b1;
                ram_wdata = it_reg.write_data;
            end
            else if (host_wr && it_reg.reg_offset == RO_DATA)
                ram_we = 1'b1;
        end
    end

    // start request and seek check of the current position
    logic hp_wrap, st_rd, st_wr, exec_rd, start_now, fault_now;

    always_comb
    begin
        hp_wrap   = hptr_reg == PW'(BUFFER_WORDS - 1);
        st_rd     = is_rd && it_reg.reg_offset == RO_DATA && hp_wrap && ops_reg == OPS_READ;
        st_wr     = host_wr && it_reg.reg_offset == RO_DATA && hp_wrap && ops_reg == OPS_WRITE;
        exec_rd   = host_wr && it_reg.reg_offset == RO_CMD && b == CMD_READ;
        start_now = st_rd || st_wr || exec_rd;
        fault_now = sect_reg == 8'd0 || sect_reg > gsec_reg[d] ||
                    {1'b0, head} >= ghd_reg[d] || cyl >= gcyl_reg[d];
        sts.start = start_now;
    end

    // host read mux
    logic [15:0] rd_v;
    logic        rd_berr;

    always_comb
    begin
        rd_v    = '0;
        rd_berr = 1'b0;
        case (it_reg.reg_offset)
            RO_DATA, RO_ERR, RO_NUL: rd_v = '0;
            RO_SCNT: rd_v = {8'h00, scnt_reg};
            RO_SECT: rd_v = {8'h00, sect_reg};
            RO_CYLL: rd_v = {8'h00, cyll_reg};
            RO_CYLH: rd_v = {8'h00, cylh_reg};
            RO_DRHD: rd_v = {8'h00, drhd_reg};
            RO_CMD, RO_CTRL: rd_v = {8'h00, stat_reg};
            default: rd_berr = 1'b1;
        endcase
    end

    logic wr_berr;
    always_comb
    begin
        case (it_reg.reg_offset)
            RO_DATA, RO_ERR, RO_SCNT, RO_SECT, RO_CYLL, RO_CYLH,
            RO_DRHD, RO_CMD, RO_CTRL, RO_NUL: wr_berr = 1'b0;
            default: wr_berr = 1'b1;
        endcase
    end

    // position advance on completion
    logic [8:0]  s_inc;
    logic [4:0]  h_inc;
    logic [15:0] c_inc;
    always_comb
    begin
        s_inc = {1'b0, sect_reg} + 9'd1;
        h_inc = {1'b0, head} + 5'd1;
        c_inc = cyl + 16'd1;
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (in_take)
            it_reg <= in_item;
    end

    // task-file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hptr_reg <= '0;
            dptr_reg <= '0;
            scnt_reg <= '0;
            sect_reg <= '0;
            cyll_reg <= '0;
            cylh_reg <= '0;
            drhd_reg <= '0;
            cmd_reg  <= '0;
            stat_reg <= '0;
            prec_reg <= '0;
            ctrl_reg <= '0;
            ops_reg  <= OPS_IDLE;
            sel_reg  <= '0;
            sfl_reg  <= 1'b0;
            for (int i = 0; i < NUM_DRIVES; i++)
            begin
                gsec_reg[i] <= 8'd17;
                ghd_reg[i]  <= 5'd4;
                gcyl_reg[i] <= 16'd306;
            end
        end
        else if (cmd.exec)
        begin
            if (start_now)
            begin
                sfl_reg  <= fault_now;
                dptr_reg <= '0;
            end
            if (is_rd && it_reg.reg_offset == RO_DATA)
            begin
                hptr_reg <= hptr_reg + PW'(1);
                if (st_rd)
                    stat_reg <= (stat_reg | ST_BUSY) & ~ST_DRQ;
            end
            else if (host_wr)
            begin
                case (it_reg.reg_offset)
                    RO_DATA:
                    begin
                        hptr_reg <= hptr_reg + PW'(1);
                        if (st_wr)
                            stat_reg <= (stat_reg | ST_BUSY) & ~ST_DRQ;
                    end
                    RO_ERR:  prec_reg <= b;
                    RO_SCNT: scnt_reg <= b;
                    RO_SECT: sect_reg <= (b == 8'd0) ? 8'd1 : b;
                    RO_CYLL: cyll_reg <= b;
                    RO_CYLH: cylh_reg <= b;
                    RO_DRHD:
                    begin
                        drhd_reg <= b;
                        sel_reg  <= b[4 +: DW];
                        if (drive_present[b[4 +: DW]])
                            stat_reg <= stat_reg | ST_READY;
                        else
                            stat_reg <= stat_reg & ~ST_READY;
                    end
                    RO_CMD:
                    begin
                        cmd_reg <= b;
                        case (b)
                            CMD_READ:
                            begin
                                ops_reg  <= OPS_READ;
                                stat_reg <= (stat_reg | ST_BUSY) & ~ST_DRQ & ~ST_ERR;
                            end
                            CMD_WRITE:
                            begin
                                ops_reg  <= OPS_WRITE;
                                stat_reg <= (stat_reg | ST_DRQ) & ~ST_BUSY & ~ST_ERR;
                            end
                            CMD_GEOM:
                            begin
                                ops_reg     <= OPS_IDLE;
                                stat_reg    <= stat_reg & ~(ST_BUSY | ST_ERR);
                                gsec_reg[d] <= sect_reg;
                                ghd_reg[d]  <= h_inc;
                                gcyl_reg[d] <= cyl;
                            end
                            default:
                            begin
                                ops_reg  <= OPS_IDLE;
                                stat_reg <= stat_reg & ~(ST_BUSY | ST_ERR);
                            end
                        endcase
                    end
                    RO_CTRL: ctrl_reg <= b;
                    default: ctrl_reg <= ctrl_reg;
                endcase
            end
            else if (is_fill || is_drain)
                dptr_reg <= dptr_reg + PW'(1);
            else if (is_done && ops_reg != OPS_IDLE)
            begin
                hptr_reg <= '0;
                dptr_reg <= '0;
                if (s_inc > {1'b0, gsec_reg[d]})
                begin
                    sect_reg <= 8'd1;
                    if (h_inc >= ghd_reg[d])
                    begin
                        drhd_reg <= {drhd_reg[7:4], 4'h0};
                        {cylh_reg, cyll_reg} <= c_inc;
                    end
                    else
                        drhd_reg <= {drhd_reg[7:4], h_inc[3:0]};
                end
                else
                    sect_reg <= s_inc[7:0];
                scnt_reg <= scnt_reg - 8'd1;
                if (ops_reg == OPS_READ)
                begin
                    stat_reg <= ((stat_reg | ST_DRQ) & ~ST_BUSY)
                                | ((sfl_reg || it_reg.io_error) ? ST_ERR : 8'h00);
                    if (scnt_reg == 8'd1)
                        ops_reg <= OPS_IDLE;
                end
                else if (scnt_reg != 8'd1)
                    stat_reg <= ((stat_reg | ST_DRQ) & ~ST_BUSY)
                                | ((sfl_reg || it_reg.io_error) ? ST_ERR : 8'h00);
                else
                begin
                    stat_reg <= (stat_reg & ~(ST_DRQ | ST_BUSY))
                                | ((sfl_reg || it_reg.io_error) ? ST_ERR : 8'h00);
                    ops_reg  <= OPS_IDLE;
                end
            end
        end
    end

    // result staging and block address pipeline
    always_ff @(posedge clk)
    begin
        // buffer word read in the exec cycle, held once the address moves on
        exec_d_reg <= cmd.exec;
        if (exec_d_reg)
            ramq_reg <= ram_rdata;
        if (cmd.exec)
        begin
            start_reg <= start_now;
            dir_reg   <= st_wr;
            fault_reg <= fault_now;
            rdsel_reg <= (is_rd && it_reg.reg_offset == RO_DATA) || is_drain;
            rdv_reg   <= is_rd ? rd_v : 16'h0000;
            berr_reg  <= (is_rd && rd_berr) || (host_wr && wr_berr);
            head_reg  <= head;
            secm1_reg <= sect_reg - 8'd1;
            gs_reg    <= gsec_reg[d];
            gh_reg    <= ghd_reg[d];
            cyl_s_reg <= cyl;
        end
        if (cmd.mul1)
            p1_reg <= 21'(cyl_s_reg * gh_reg) + 21'(head_reg);
        if (cmd.mul2)
            ba_reg <= 28'(p1_reg * gs_reg) + 28'(secm1_reg);
        if (cmd.load_out)
        begin
            res_reg.read_data      <= rdsel_reg ? (exec_d_reg ? ram_rdata : ramq_reg)
                                                : rdv_reg;
            res_reg.bad_access     <= berr_reg;
            res_reg.start_transfer <= start_reg;
            res_reg.transfer_dir   <= start_reg & dir_reg;
            res_reg.transfer_drive <= start_reg & sel_reg[0];
            res_reg.block_address  <= (start_reg && !fault_reg) ? ba_reg : 28'd0;
            res_reg.seek_fault     <= start_reg & fault_reg;
        end
    end

    assign out_item = res_reg;

    // unused register contents kept for the window
    logic unused_ok;
    assign unused_ok = ^{prec_reg, ctrl_reg, cmd_reg};
endmodule

>>> hw/rtl/winchester_disk_task_file_controller_unit.sv
// ============================================================================
// winchester_disk_task_file_controller_unit - task-file disk controller
// Host register window, one-sector buffer and block address generation.
// ============================================================================
// Sequence: an item with no sector transfer passes execute and result load; one
// that starts a transfer also passes the two multiply stages. One item at a time:
// the sequencer takes no new item before the last is loaded, and a stalled result
// holds the next item at result load.
// Reset: rst_n clears task file, pointers and state; geometry returns to
// 17 sectors, 4 heads, 306 cylinders; buffer contents stay undefined.
module winchester_disk_task_file_controller_unit #(
    parameter int BUFFER_WORDS = wdtf_pkg::BUFFER_WORDS_DEF,
    parameter int NUM_DRIVES   = wdtf_pkg::NUM_DRIVES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  wdtf_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output wdtf_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NUM_DRIVES-1:0] cfg_data
);
    import wdtf_pkg::*;

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    logic [NUM_DRIVES-1:0] present_reg;

    // drive present register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            present_reg <= NUM_DRIVES'(1);
        else if (cfg_valid && cfg_ready)
            present_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    wdtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wdtf_dp #(.BUFFER_WORDS(BUFFER_WORDS), .NUM_DRIVES(NUM_DRIVES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_take       (in_valid && !in_stall),
        .in_item       (in_data),
        .drive_present (present_reg),
        .cmd           (cmd),
        .sts           (sts),
        .out_item      (out_data)
    );
endmodule

>>> hw/rtl/wdtf_checker.sv
// ============================================================================
// wdtf_checker - port-level checks for the task-file controller
// Watches the handshakes and the result fields over time.
// ============================================================================
module wdtf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input wdtf_pkg::out_item_t out_data
);
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // no result fields without a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.start_transfer |->
            out_data.block_address == 28'd0 && !out_data.seek_fault)
        else $error("transfer fields without start");

    // a fault never carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.seek_fault |-> out_data.block_address == 28'd0)
        else $error("address on seek fault");

    // an accepted item is not followed by another in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");
endmodule

bind winchester_disk_task_file_controller_unit wdtf_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> dv/winchester_disk_task_file_controller_unit_test.sv
// ============================================================================
// winchester_disk_task_file_controller_unit_test - task-file controller bench
// Drives host register accesses and disk-side buffer traffic into the block,
// predicts each result with an in-bench model of the controller, and checks
// every output transfer in order against the predicted one.
// ============================================================================
module winchester_disk_task_file_controller_unit_test;
    import wdtf_pkg::*;

    // ------------------------------------------------------------------
    // Controller predictor and result queue
    // ------------------------------------------------------------------
    class disk_ctl_scoreboard;
        logic [1:0]  present;
        logic [15:0] sbuf [256];
        bit          written [256];
        logic [7:0]  hptr, dptr, scnt, sect, cyl_lo, cyl_hi, drhd, cmd_reg, status;
        logic [7:0]  precomp, ctrl;
        ops_t        mode;
        logic        drive, fault_held;
        logic [7:0]  g_sect [2];
        logic [4:0]  g_heads [2];
        logic [15:0] g_cyls [2];
        out_item_t   pending [$];
        int          errors;

        function void clear();
            present = 2'd1;
            hptr = 0; dptr = 0; scnt = 0; sect = 0; cyl_lo = 0; cyl_hi = 0;
            drhd = 0; cmd_reg = 0; status = 0; precomp = 0; ctrl = 0;
            mode = OPS_IDLE; drive = 0; fault_held = 0;
            foreach (written[i]) written[i] = 0;
            for (int i = 0; i < 2; i++)
            begin
                g_sect[i] = 8'd17; g_heads[i] = 5'd4; g_cyls[i] = 16'd306;
            end
            pending.delete();
        endfunction

        function void launch(ref out_item_t r, input logic dir);
            logic [15:0] cyl;
            logic [3:0]  hd;
            logic        flt;
            longint      ba;
            cyl = {cyl_hi, cyl_lo};
            hd  = drhd[3:0];
            flt = (sect < 1) || (sect > g_sect[drive]) || (hd >= g_heads[drive])
                  || (cyl >= g_cyls[drive]);
            ba = 0;
            if (!flt)
                ba = (longint'(cyl) * g_heads[drive] + hd) * g_sect[drive] + (sect - 1);
            fault_held = flt;
            dptr = 0;
            r.start_transfer = 1;
            r.transfer_dir = dir;
            r.transfer_drive = drive;
            r.block_address = ba[27:0];
            r.seek_fault = flt;
        endfunction

        function void host_wr(logic [4:0] off, logic [7:0] b, ref out_item_t r);
            case (off)
                RO_DATA:
                begin
                    sbuf[hptr] = {8'h00, b}; written[hptr] = 1;
                    hptr++;
                    if (hptr == 0 && mode == OPS_WRITE)
                    begin
                        status = (status | ST_BUSY) & ~ST_DRQ;
                        launch(r, 1'b1);
                    end
                end
                RO_ERR:  precomp = b;
                RO_SCNT: scnt = b;
                RO_SECT: sect = (b != 0) ? b : 8'd1;
                RO_CYLL: cyl_lo = b;
                RO_CYLH: cyl_hi = b;
                RO_DRHD:
                begin
                    drhd = b; drive = b[4];
                    if (present[drive]) status |= ST_READY;
                    else status &= ~ST_READY;
                end
                RO_CMD:
                begin
                    cmd_reg = b;
                    mode = OPS_IDLE;
                    status &= ~(ST_BUSY | ST_ERR);
                    if (b == CMD_READ)
                    begin
                        mode = OPS_READ;
                        status = (status | ST_BUSY) & ~ST_DRQ;
                        launch(r, 1'b0);
                    end
                    else if (b == CMD_WRITE)
                    begin
                        mode = OPS_WRITE;
                        status = (status | ST_DRQ) & ~ST_BUSY;
                    end
                    else if (b == CMD_GEOM)
                    begin
                        g_sect[drive] = sect;
                        g_heads[drive] = drhd[3:0] + 5'd1;
                        g_cyls[drive] = {cyl_hi, cyl_lo};
                    end
                end
                RO_CTRL: ctrl = b;
                RO_NUL: ;
                default: r.bad_access = 1;
            endcase
        endfunction

        function void finish_sector(logic ioerr);
            logic [8:0]  s;
            logic [4:0]  hd;
            logic [15:0] cyl;
            if (mode != OPS_READ && mode != OPS_WRITE) return;
            if (fault_held || ioerr) status |= ST_ERR;
            hptr = 0; dptr = 0;
            s = sect + 9'd1;
            if (s > g_sect[drive])
            begin
                hd = drhd[3:0] + 5'd1;
                sect = 1;
                drhd &= 8'hf0;
                if (hd >= g_heads[drive])
                begin
                    cyl = {cyl_hi, cyl_lo} + 16'd1;
                    {cyl_hi, cyl_lo} = cyl;
                end
                else drhd |= {4'h0, hd[3:0]};
            end
            else sect = s[7:0];
            scnt--;
            if (mode == OPS_READ)
            begin
                status = (status | ST_DRQ) & ~ST_BUSY;
                if (scnt == 0) mode = OPS_IDLE;
            end
            else if (scnt != 0) status = (status | ST_DRQ) & ~ST_BUSY;
            else
            begin
                status &= ~(ST_DRQ | ST_BUSY);
                mode = OPS_IDLE;
            end
        endfunction

        // would this item read an unwritten buffer word?
        function bit touches_blank(in_item_t it);
            if (it.command == OP_DRAIN) return !written[dptr];
            if (it.command == OP_HOST_RD && it.reg_offset == RO_DATA) return !written[hptr];
            return 0;
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            r = '0;
            case (it.command)
                OP_HOST_RD:
                    case (it.reg_offset)
                        RO_DATA:
                        begin
                            r.read_data = sbuf[hptr];
                            hptr++;
                            if (hptr == 0 && mode == OPS_READ)
                            begin
                                status = (status | ST_BUSY) & ~ST_DRQ;
                                launch(r, 1'b0);
                            end
                        end
                        RO_ERR, RO_NUL: r.read_data = 0;
                        RO_SCNT: r.read_data = scnt;
                        RO_SECT: r.read_data = sect;
                        RO_CYLL: r.read_data = cyl_lo;
                        RO_CYLH: r.read_data = cyl_hi;
                        RO_DRHD: r.read_data = drhd;
                        RO_CMD, RO_CTRL: r.read_data = status;
                        default: r.bad_access = 1;
                    endcase
                OP_HOST_WR: host_wr(it.reg_offset, it.write_data[7:0], r);
                OP_HOST_BW: if (!it.reg_offset[0]) host_wr(it.reg_offset, it.write_data[7:0], r);
                OP_FILL:
                begin
                    sbuf[dptr] = it.write_data; written[dptr] = 1; dptr++;
                end
                OP_DRAIN:
                begin
                    r.read_data = sbuf[dptr]; dptr++;
                end
                OP_DONE: finish_sector(it.io_error);
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("result differs: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
    in_item_t    in_data;
    out_item_t   out_data;
    logic [1:0]  cfg_data;
    disk_ctl_scoreboard board;
    int          cycle_count;
    bit          hold_off_req;
    int          items_sent;

    winchester_disk_task_file_controller_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // output checking at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 600000)
        begin
            $display("winchester_disk_task_file_controller_unit: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver stalls, with one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (150) @(negedge clk);
                hold_off_req = 0;
                out_stall <= 1'b0;
            end
            else if (items_sent > 1000 || $urandom_range(0, 3) == 0)
                out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // one input transfer, then a random gap; blank-word reads are skipped
    task automatic send_item(in_item_t it);
        int n;
        if (board.touches_blank(it))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            return;
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(it);
        items_sent++;
        @(negedge clk);
        n = (items_sent > 1000 && items_sent < 1200) ? 0 : gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic put(logic [2:0] c, logic [4:0] o, logic [15:0] d, logic e = 0);
        in_item_t it;
        it.command = c; it.reg_offset = o; it.write_data = d; it.io_error = e;
        send_item(it);
    endtask

    task automatic write_present(logic [1:0] v);
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.present = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [4:0] rand_offset();
        if ($urandom_range(0, 9) < 8) return 5'($urandom_range(0, 9) * 2);
        return 5'($urandom_range(0, 31));
    endfunction

    // a well-formed read or write run with random content
    task automatic sector_run(bit is_wr);
        int secs, words;
        secs  = 1;
        words = 256;
        put(OP_HOST_WR, RO_SCNT, 16'($urandom_range(1, 2)));
        put(OP_HOST_WR, RO_SECT, 16'($urandom_range(0, 20)));
        put(OP_HOST_WR, RO_CYLL, 16'($urandom));
        put(OP_HOST_WR, RO_CYLH, 16'($urandom_range(0, 2)));
        put(OP_HOST_BW, RO_DRHD, 16'($urandom_range(0, 255)));
        put(OP_HOST_WR, RO_CMD, 16'(is_wr ? CMD_WRITE : CMD_READ));
        for (int s = 0; s < secs; s++)
        begin
            if (is_wr)
            begin
                for (int w = 0; w < words; w++) put(OP_HOST_WR, RO_DATA, 16'($urandom));
                for (int w = 0; w < 8; w++) put(OP_DRAIN, 0, 16'($urandom));
            end
            else
                for (int w = 0; w < words; w++) put(OP_FILL, 0, 16'($urandom));
            put(OP_DONE, 0, 0, $urandom_range(0, 5) == 0);
            if (!is_wr)
                for (int w = 0; w < words; w++) put(OP_HOST_RD, RO_DATA, 0);
            put(OP_HOST_RD, RO_CMD, 0);
        end
    endtask

    task automatic noise_item();
        put(3'($urandom_range(0, 7)), rand_offset(), 16'($urandom), 1'($urandom));
    endtask

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        cycle_count = 0; hold_off_req = 0; items_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: register window, odd and undecoded offsets, commands
        write_present(2'b11);
        put(OP_HOST_WR, RO_SECT, 16'h0000);
        put(OP_HOST_RD, RO_SECT, 0);
        put(OP_HOST_WR, RO_ERR, 16'hffff);
        put(OP_HOST_RD, RO_ERR, 0);
        put(OP_HOST_BW, 5'd7, 16'h00aa);
        put(OP_HOST_RD, 5'd31, 0);
        put(OP_HOST_WR, 5'd20, 16'h1234);
        put(OP_HOST_WR, RO_CTRL, 16'hff);
        put(OP_HOST_RD, RO_NUL, 0);
        put(OP_HOST_WR, RO_DRHD, 16'h001f);
        put(OP_HOST_RD, RO_CTRL, 0);
        put(OP_DONE, 0, 0, 1);
        put(OP_HOST_WR, RO_CMD, 16'h0055);
        put(3'd6, 0, 16'hffff, 1);
        put(3'd7, 5'd31, 16'h0000, 0);
        put(OP_HOST_WR, RO_SCNT, 0);
        put(OP_HOST_WR, RO_CYLH, 16'hff);
        put(OP_HOST_WR, RO_CYLL, 16'hff);
        put(OP_HOST_WR, RO_SECT, 16'hff);
        put(OP_HOST_WR, RO_DRHD, 16'h000f);
        put(OP_HOST_WR, RO_CMD, 16'(CMD_GEOM));
        put(OP_HOST_WR, RO_CMD, 16'(CMD_READ));
        put(OP_DONE, 0, 0, 0);
        put(OP_HOST_RD, RO_SCNT, 0);
        drain_results();

        // random phases over several drive-present settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_present(2'(ph));
            if (ph == 2) hold_off_req = 1;
            sector_run(ph[0]);
            repeat (10) noise_item();
            drain_results();
        end

        in_valid <= 1'b0;
        drain_results();
        if (board.errors == 0)
            $display("winchester_disk_task_file_controller_unit: match");
        else
            $display("winchester_disk_task_file_controller_unit: mismatch");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/wdtf_pkg.sv
hw/rtl/wdtf_ram.sv
hw/rtl/wdtf_ctrl.sv
hw/rtl/wdtf_dp.sv
hw/rtl/winchester_disk_task_file_controller_unit.sv
hw/rtl/wdtf_checker.sv
dv/winchester_disk_task_file_controller_unit_test.sv
